@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL. They expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/symeig_pkg.sv @@
package symeig_pkg;

  localparam int MAX_ITERATIONS = 64;
  localparam int MemDepth = 64;

  localparam logic [6:0] ITER_RESET = 7'd16;

  typedef logic signed [34:0] word_t;

  localparam word_t AK_LIM = 35'sd8589934591;
  localparam word_t ONE_Q30 = 35'sd1073741824;

  localparam logic [5:0] BASE_AK  = 6'd0;
  localparam logic [5:0] BASE_V   = 6'd9;
  localparam logic [5:0] BASE_Q1  = 6'd18;
  localparam logic [5:0] BASE_Q2  = 6'd27;
  localparam logic [5:0] BASE_P   = 6'd36;
  localparam logic [5:0] BASE_Q   = 6'd45;
  localparam logic [5:0] BASE_TMP = 6'd54;

  typedef struct packed {
    logic signed [31:0] elem_00;
    logic signed [31:0] elem_01;
    logic signed [31:0] elem_02;
    logic signed [31:0] elem_11;
    logic signed [31:0] elem_12;
    logic signed [31:0] elem_22;
  } mat_t;

  typedef struct packed {
    logic signed [31:0] eigval_0;
    logic signed [31:0] eigval_1;
    logic signed [31:0] eigval_2;
    logic signed [31:0] evec_00;
    logic signed [31:0] evec_01;
    logic signed [31:0] evec_02;
    logic signed [31:0] evec_10;
    logic signed [31:0] evec_11;
    logic signed [31:0] evec_12;
    logic signed [31:0] evec_20;
    logic signed [31:0] evec_21;
    logic signed [31:0] evec_22;
  } eig_t;

endpackage

@@ hw/rtl/symmetric_eigen_qr_iteration_3x3.sv @@
// Eigendecomposition of a symmetric 3x3 matrix by unshifted QR iteration.
// The input channel (mat_valid, mat_ready, mat) takes the upper triangle of
// the matrix in signed Q16.16. The output channel (eig_valid, eig_ready, eig)
// returns the three eigenvalues in Q16.16 and the eigenvector matrix in Q2.30.
// The APB port holds iteration_count at address 0; write it only while idle.
// The iteration count is capped at 64. Each iteration runs two Householder
// reflectors (two integer square roots and three bit-serial divisions
// each) and five 3x3 matrix products, all on one shared multiplier and
// one register-file memory.
// The block takes one item at a time; mat_ready is high only while idle.
// A finished result waits in the output register, and a new item is taken
// meanwhile. If the receiver still stalls when the next result is ready,
// the block holds that result until the output register frees up.
// Synchronous reset sets iteration_count to 16 and empties the block.
`include "assert_macros.svh"
module symmetric_eigen_qr_iteration_3x3 (
  input  logic               clk,
  input  logic               rst,
  input  logic               mat_valid,
  output logic               mat_ready,
  input  symeig_pkg::mat_t   mat,
  output logic               eig_valid,
  input  logic               eig_ready,
  output symeig_pkg::eig_t   eig,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import symeig_pkg::*;

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_LOAD  = 5'd1;
  localparam logic [4:0] S_ITER  = 5'd2;
  localparam logic [4:0] S_NEXT  = 5'd3;
  localparam logic [4:0] S_XRD   = 5'd4;
  localparam logic [4:0] S_SCL   = 5'd5;
  localparam logic [4:0] S_SHR   = 5'd6;
  localparam logic [4:0] S_SHL   = 5'd7;
  localparam logic [4:0] S_APPLY = 5'd8;
  localparam logic [4:0] S_SQ    = 5'd9;
  localparam logic [4:0] S_SQRT  = 5'd10;
  localparam logic [4:0] S_USUB  = 5'd11;
  localparam logic [4:0] S_DIVI  = 5'd12;
  localparam logic [4:0] S_DIV   = 5'd13;
  localparam logic [4:0] S_DIVE  = 5'd14;
  localparam logic [4:0] S_HOUSE = 5'd15;
  localparam logic [4:0] S_MM    = 5'd16;
  localparam logic [4:0] S_COPY  = 5'd17;
  localparam logic [4:0] S_OUT   = 5'd18;
  localparam logic [4:0] S_PUSH  = 5'd19;

  localparam logic [3:0] STP_REFL1 = 4'd0;
  localparam logic [3:0] STP_HQ1   = 4'd1;
  localparam logic [3:0] STP_MM_P  = 4'd2;
  localparam logic [3:0] STP_REFL2 = 4'd3;
  localparam logic [3:0] STP_HQ2   = 4'd4;
  localparam logic [3:0] STP_MM_Q  = 4'd5;
  localparam logic [3:0] STP_MM_V  = 4'd6;
  localparam logic [3:0] STP_MM_L  = 4'd7;
  localparam logic [3:0] STP_MM_R  = 4'd8;

  localparam logic [1:0] ADDR_ITER = 2'd0;

  function automatic logic signed [37:0] rnd_sh(input logic signed [66:0] x, input int s);
    logic [66:0] m;
    logic [36:0] r;
    m = x[66] ? 67'(-x) : 67'(x);
    r = 37'((m + (67'd1 << (s - 1))) >> s);
    return x[66] ? -$signed({1'b0, r}) : $signed({1'b0, r});
  endfunction

  function automatic word_t clampw(input logic signed [39:0] x, input word_t lim);
    if (x > lim) begin
      return lim;
    end else if (x < -lim) begin
      return -lim;
    end
    return $signed(x[34:0]);
  endfunction

  function automatic logic [34:0] mag35(input word_t v);
    return v[34] ? 35'(-v) : 35'(v);
  endfunction

  function automatic logic signed [31:0] sat32(input word_t v);
    if (v > 35'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -35'sd2147483648) begin
      return 32'sh80000000;
    end
    return $signed(v[31:0]);
  endfunction

  // Configuration.
  logic [6:0] iter_cfg;
  logic [6:0] iters;

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_cfg <= ITER_RESET;
    end else if (psel && penable && pwrite && paddr == ADDR_ITER) begin
      iter_cfg <= pwdata[6:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr == ADDR_ITER) ? {25'd0, iter_cfg} : 32'd0;
  assign iters = (iter_cfg > 7'(MAX_ITERATIONS)) ? 7'(MAX_ITERATIONS) : iter_cfg;

  // Matrix store and shared multiplier.
  word_t mem [MemDepth];
  logic mem_we;
  logic [5:0] mem_wa, ra_a, ra_b;
  word_t mem_wd, rd_a, rd_b;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_a <= mem[ra_a];
    rd_b <= mem[ra_b];
  end

  word_t mul_a;
  logic signed [31:0] mul_b;
  logic signed [66:0] prod;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Control and datapath registers.
  logic [4:0] state;
  logic [3:0] step;
  logic [6:0] kcnt;
  logic [5:0] cnt;
  logic pass;
  mat_t in_reg;
  word_t x [3];
  logic signed [31:0] vv [3];
  logic [34:0] m_sh;
  logic [2:0] sh_r;
  logic [4:0] sh_l;
  logic [63:0] sq_acc, sq_x, sq_res, sq_bit;
  logic [63:0] num;
  logic [32:0] dq;
  logic [1:0] di;
  logic [1:0] mi, mj, mk;
  logic issue_done;
  logic p1_v, p1_last, p2_v, p2_last;
  logic [3:0] p1_idx, p2_idx;
  logic signed [39:0] acc;
  logic [1:0] hr, hc;
  logic h_done, h1_v, h1_in, h1_diag;
  logic [3:0] h1_idx;
  word_t ost [12];

  // Product routing for the current step.
  logic [5:0] a_base, b_base, d_base;
  logic a_tr, b_wide;
  word_t lim;

  always_comb begin
    a_base = BASE_Q1;
    b_base = BASE_AK;
    d_base = BASE_P;
    a_tr = 1'b0;
    b_wide = 1'b1;
    lim = AK_LIM;
    unique case (step)
      STP_MM_Q: begin
        b_base = BASE_Q2;
        d_base = BASE_Q;
        lim = ONE_Q30;
      end
      STP_MM_V: begin
        a_base = BASE_V;
        b_base = BASE_Q;
        d_base = BASE_V;
        lim = ONE_Q30;
      end
      STP_MM_L: begin
        a_base = BASE_Q;
        a_tr = 1'b1;
        d_base = BASE_AK;
      end
      STP_MM_R: begin
        a_base = BASE_AK;
        b_base = BASE_Q;
        b_wide = 1'b0;
        d_base = BASE_AK;
      end
      default: begin
      end
    endcase
  end

  logic [34:0] mx;
  logic [1:0] h_off;
  logic signed [31:0] h_vi, h_vj;
  logic [1:0] h_ii, h_jj;
  logic h_inblk;
  logic signed [37:0] mm_term;
  logic [63:0] sq_sum, div_sh;
  word_t diag_val;
  logic [3:0] ak_idx, v_idx;
  word_t load_wd;

  always_comb begin
    logic [34:0] m0, m1, m2;
    m0 = mag35(x[0]);
    m1 = mag35(x[1]);
    m2 = mag35(x[2]);
    mx = m0;
    if (m1 > mx) begin
      mx = m1;
    end
    if (m2 > mx) begin
      mx = m2;
    end
  end

  assign h_off = (step == STP_HQ1) ? 2'd0 : 2'd1;
  assign h_inblk = (hr >= h_off) && (hc >= h_off);
  assign h_ii = hr - h_off;
  assign h_jj = hc - h_off;
  assign h_vi = (h_ii == 2'd0) ? vv[0] : ((h_ii == 2'd1) ? vv[1] : vv[2]);
  assign h_vj = (h_jj == 2'd0) ? vv[0] : ((h_jj == 2'd1) ? vv[1] : vv[2]);
  assign mm_term = rnd_sh(prod, 30);
  assign sq_sum = sq_res + sq_bit;
  assign div_sh = sq_res << cnt;
  assign diag_val = h1_diag ? ONE_Q30 : 35'sd0;
  assign ak_idx = cnt[3:0];
  assign v_idx = 4'(cnt - 6'd9);

  always_comb begin
    unique case (ak_idx)
      4'd0: load_wd = 35'($signed(in_reg.elem_00));
      4'd1, 4'd3: load_wd = 35'($signed(in_reg.elem_01));
      4'd2, 4'd6: load_wd = 35'($signed(in_reg.elem_02));
      4'd4: load_wd = 35'($signed(in_reg.elem_11));
      4'd5, 4'd7: load_wd = 35'($signed(in_reg.elem_12));
      4'd8: load_wd = 35'($signed(in_reg.elem_22));
      default: load_wd = 35'sd0;
    endcase
  end

  // Memory ports and multiplier operands.
  always_comb begin
    logic [3:0] aidx, bidx;
    aidx = a_tr ? (4'(mk) * 4'd3 + 4'(mi)) : (4'(mi) * 4'd3 + 4'(mk));
    bidx = 4'(mk) * 4'd3 + 4'(mj);
    ra_a = 6'd0;
    ra_b = 6'd0;
    mem_we = 1'b0;
    mem_wa = 6'd0;
    mem_wd = 35'sd0;
    mul_a = 35'sd0;
    mul_b = 32'sd0;
    unique case (state)
      S_LOAD: begin
        mem_we = 1'b1;
        mem_wa = cnt;
        if (cnt < 6'd9) begin
          mem_wd = load_wd;
        end else begin
          mem_wd = (v_idx == 4'd0 || v_idx == 4'd4 || v_idx == 4'd8) ? ONE_Q30 : 35'sd0;
        end
      end
      S_XRD: begin
        ra_a = ((step == STP_REFL1) ? BASE_AK : (BASE_P + 6'd4)) + 6'(cnt[1:0]) * 6'd3;
      end
      S_SQ: begin
        unique case (cnt[1:0])
          2'd0: begin
            mul_a = x[0];
            mul_b = x[0][31:0];
          end
          2'd1: begin
            mul_a = x[1];
            mul_b = x[1][31:0];
          end
          2'd2: begin
            mul_a = x[2];
            mul_b = x[2][31:0];
          end
          default: begin
          end
        endcase
      end
      S_HOUSE: begin
        mul_a = 35'(h_vi);
        mul_b = h_vj;
        if (h1_v) begin
          mem_we = 1'b1;
          mem_wa = ((step == STP_HQ1) ? BASE_Q1 : BASE_Q2) + 6'(h1_idx);
          mem_wd = h1_in ? clampw(40'(diag_val) - 40'(rnd_sh(prod, 29)), ONE_Q30) : diag_val;
        end
      end
      S_MM: begin
        ra_a = a_base + 6'(aidx);
        ra_b = b_base + 6'(bidx);
        if (b_wide) begin
          mul_a = rd_b;
          mul_b = rd_a[31:0];
        end else begin
          mul_a = rd_a;
          mul_b = rd_b[31:0];
        end
        if (p2_v && p2_last) begin
          mem_we = 1'b1;
          mem_wa = BASE_TMP + 6'(p2_idx);
          mem_wd = clampw(acc + 40'(mm_term), lim);
        end
      end
      S_COPY: begin
        ra_a = BASE_TMP + cnt;
        if (cnt != 6'd0) begin
          mem_we = 1'b1;
          mem_wa = d_base + cnt - 6'd1;
          mem_wd = rd_a;
        end
      end
      S_OUT: begin
        if (cnt < 6'd3) begin
          ra_a = BASE_AK + cnt * 6'd4;
        end else begin
          ra_a = BASE_V + cnt - 6'd3;
        end
      end
      default: begin
      end
    endcase
  end

  assign mat_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      eig_valid <= 1'b0;
      step <= STP_REFL1;
      kcnt <= 7'd0;
      cnt <= 6'd0;
      pass <= 1'b0;
      issue_done <= 1'b0;
      p1_v <= 1'b0;
      p2_v <= 1'b0;
      h_done <= 1'b0;
      h1_v <= 1'b0;
    end else begin
      if (eig_valid && eig_ready && state != S_PUSH) begin
        eig_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (mat_valid) begin
            in_reg <= mat;
            cnt <= 6'd0;
            state <= S_LOAD;
          end
        end
        S_LOAD: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd17) begin
            kcnt <= 7'd0;
            state <= S_ITER;
          end
        end
        S_ITER: begin
          cnt <= 6'd0;
          step <= STP_REFL1;
          state <= (kcnt == iters) ? S_OUT : S_NEXT;
        end
        S_NEXT: begin
          cnt <= 6'd0;
          mi <= 2'd0;
          mj <= 2'd0;
          mk <= 2'd0;
          issue_done <= 1'b0;
          p1_v <= 1'b0;
          p2_v <= 1'b0;
          acc <= 40'sd0;
          hr <= 2'd0;
          hc <= 2'd0;
          h_done <= 1'b0;
          h1_v <= 1'b0;
          pass <= 1'b0;
          unique case (step)
            STP_REFL1, STP_REFL2: state <= S_XRD;
            STP_HQ1, STP_HQ2: state <= S_HOUSE;
            STP_MM_P, STP_MM_Q, STP_MM_V, STP_MM_L, STP_MM_R: state <= S_MM;
            default: state <= S_ITER;
          endcase
        end
        S_XRD: begin
          cnt <= cnt + 6'd1;
          if (cnt != 6'd0) begin
            x[cnt[1:0] - 2'd1] <= (step == STP_REFL2 && cnt == 6'd3) ? 35'sd0 : rd_a;
          end
          if (cnt == 6'd3) begin
            state <= S_SCL;
          end
        end
        S_SCL: begin
          if (mx == 35'd0) begin
            vv[0] <= 32'sd0;
            vv[1] <= 32'sd0;
            vv[2] <= 32'sd0;
            step <= step + 4'd1;
            state <= S_NEXT;
          end else begin
            m_sh <= mx;
            sh_r <= 3'd0;
            sh_l <= 5'd0;
            state <= S_SHR;
          end
        end
        S_SHR: begin
          if (m_sh >= (35'd1 << 30)) begin
            m_sh <= m_sh >> 1;
            sh_r <= sh_r + 3'd1;
          end else begin
            state <= S_SHL;
          end
        end
        S_SHL: begin
          if (m_sh < (35'd1 << 29)) begin
            m_sh <= m_sh << 1;
            sh_l <= sh_l + 5'd1;
          end else begin
            state <= S_APPLY;
          end
        end
        S_APPLY: begin
          for (int i = 0; i < 3; i++) begin
            logic [34:0] t;
            t = (sh_r != 3'd0) ? (mag35(x[i]) >> sh_r) : (mag35(x[i]) << sh_l);
            x[i] <= x[i][34] ? $signed(-t) : $signed(t);
          end
          cnt <= 6'd0;
          sq_acc <= 64'd0;
          state <= S_SQ;
        end
        S_SQ: begin
          if (cnt != 6'd0) begin
            sq_acc <= sq_acc + prod[63:0];
          end
          if (cnt == 6'd3) begin
            sq_x <= sq_acc + prod[63:0];
            sq_res <= 64'd0;
            sq_bit <= 64'd1 << 62;
            cnt <= 6'd0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 6'd1;
          end
        end
        S_SQRT: begin
          if (sq_x >= sq_sum) begin
            sq_x <= sq_x - sq_sum;
            sq_res <= (sq_res >> 1) + sq_bit;
          end else begin
            sq_res <= sq_res >> 1;
          end
          sq_bit <= sq_bit >> 2;
          cnt <= cnt + 6'd1;
          di <= 2'd0;
          if (cnt == 6'd31) begin
            state <= pass ? S_DIVI : S_USUB;
          end
        end
        S_USUB: begin
          x[0] <= x[0] - $signed({1'b0, sq_res[33:0]});
          pass <= 1'b1;
          state <= S_SCL;
        end
        S_DIVI: begin
          num <= ({29'd0, mag35(x[di])} << 30) + (sq_res >> 1);
          dq <= 33'd0;
          cnt <= 6'd32;
          state <= S_DIV;
        end
        S_DIV: begin
          if (num >= div_sh) begin
            num <= num - div_sh;
            dq[cnt] <= 1'b1;
          end
          if (cnt == 6'd0) begin
            state <= S_DIVE;
          end else begin
            cnt <= cnt - 6'd1;
          end
        end
        S_DIVE: begin
          vv[di] <= x[di][34] ? -$signed({1'b0, dq[30:0]}) : $signed({1'b0, dq[30:0]});
          if (di == 2'd2) begin
            step <= step + 4'd1;
            state <= S_NEXT;
          end else begin
            di <= di + 2'd1;
            state <= S_DIVI;
          end
        end
        S_HOUSE: begin
          h1_v <= !h_done;
          h1_idx <= 4'(hr) * 4'd3 + 4'(hc);
          h1_in <= h_inblk;
          h1_diag <= (hr == hc);
          if (!h_done) begin
            if (hc == 2'd2) begin
              hc <= 2'd0;
              if (hr == 2'd2) begin
                h_done <= 1'b1;
              end else begin
                hr <= hr + 2'd1;
              end
            end else begin
              hc <= hc + 2'd1;
            end
          end
          if (h1_v && h1_idx == 4'd8) begin
            step <= step + 4'd1;
            state <= S_NEXT;
          end
        end
        S_MM: begin
          p1_v <= !issue_done;
          p1_last <= (mk == 2'd2);
          p1_idx <= 4'(mi) * 4'd3 + 4'(mj);
          p2_v <= p1_v;
          p2_last <= p1_last;
          p2_idx <= p1_idx;
          if (!issue_done) begin
            if (mk == 2'd2) begin
              mk <= 2'd0;
              if (mj == 2'd2) begin
                mj <= 2'd0;
                if (mi == 2'd2) begin
                  issue_done <= 1'b1;
                end else begin
                  mi <= mi + 2'd1;
                end
              end else begin
                mj <= mj + 2'd1;
              end
            end else begin
              mk <= mk + 2'd1;
            end
          end
          if (p2_v) begin
            acc <= p2_last ? 40'sd0 : (acc + 40'(mm_term));
            if (p2_last && p2_idx == 4'd8) begin
              cnt <= 6'd0;
              state <= S_COPY;
            end
          end
        end
        S_COPY: begin
          cnt <= cnt + 6'd1;
          if (cnt == 6'd9) begin
            if (step == STP_MM_R) begin
              kcnt <= kcnt + 7'd1;
              state <= S_ITER;
            end else begin
              step <= step + 4'd1;
              state <= S_NEXT;
            end
          end
        end
        S_OUT: begin
          cnt <= cnt + 6'd1;
          if (cnt != 6'd0) begin
            ost[4'(cnt - 6'd1)] <= rd_a;
          end
          if (cnt == 6'd12) begin
            state <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!eig_valid || eig_ready) begin
            eig.eigval_0 <= sat32(ost[0]);
            eig.eigval_1 <= sat32(ost[1]);
            eig.eigval_2 <= sat32(ost[2]);
            eig.evec_00 <= $signed(ost[3][31:0]);
            eig.evec_01 <= $signed(ost[4][31:0]);
            eig.evec_02 <= $signed(ost[5][31:0]);
            eig.evec_10 <= $signed(ost[6][31:0]);
            eig.evec_11 <= $signed(ost[7][31:0]);
            eig.evec_12 <= $signed(ost[8][31:0]);
            eig.evec_20 <= $signed(ost[9][31:0]);
            eig.evec_21 <= $signed(ost[10][31:0]);
            eig.evec_22 <= $signed(ost[11][31:0]);
            eig_valid <= 1'b1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic refl_ok;
  assign refl_ok = (vv[0] <= 32'sd1073741824) && (vv[0] >= -32'sd1073741824)
                && (vv[1] <= 32'sd1073741824) && (vv[1] >= -32'sd1073741824)
                && (vv[2] <= 32'sd1073741824) && (vv[2] >= -32'sd1073741824);

  `ASSERT_SAME(a_kcnt_range, state == S_NEXT, kcnt < iters, "iteration count overrun")
  `ASSERT_SAME(a_sqrt_bit, state == S_SQRT, $onehot(sq_bit), "square root bit lost")
  `ASSERT_SAME(a_refl_range, state == S_HOUSE, refl_ok, "reflector entry out of range")
  `ASSERT_NEXT(a_accept_load, mat_valid && mat_ready, state == S_LOAD, "accepted item not loaded")

endmodule
